[rtl/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("implication check failed");

// next-cycle implication
`define CHK_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("next-cycle check failed");

`endif

[rtl/ffa_pkg.sv]
package ffa_pkg;

	localparam int ARENA_MAX_BYTES   = 4096;
	localparam int ALIGN_BYTES       = 8;
	localparam int HEADER_BYTES      = 16;
	localparam int MIN_PAYLOAD_BYTES = 8;

	localparam int ALIGN_SH = $clog2(ALIGN_BYTES);
	localparam int DEPTH    = ARENA_MAX_BYTES / ALIGN_BYTES;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int SIZE_W   = $clog2(ARENA_MAX_BYTES);
	localparam int ARENA_W  = SIZE_W + 1;
	localparam int OFS_W    = SIZE_W + 2;
	localparam int REQ_W    = 16;
	localparam int NEED_W   = REQ_W + 1;
	localparam int FOFS_W   = 12;
	localparam int STAT_W   = 2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
	localparam logic [STAT_W-1:0] ST_ZERO  = 2'd2;
	localparam logic [STAT_W-1:0] ST_BAD   = 2'd3;

	typedef struct packed {
		logic              valid;
		logic              alloc;
		logic              has_prev;
		logic [SIZE_W-1:0] size;
		logic [IDX_W-1:0]  prev;
	} tag_t;

	localparam int TAG_W = $bits(tag_t);

	typedef enum logic [4:0] {
		OP_NOP, OP_CLR, OP_INIT, OP_START, OP_RD_BLK, OP_EVAL_A, OP_SPLIT, OP_TAKE,
		OP_LNK_RD, OP_LNK_WR, OP_EVAL_F, OP_RD_OTH, OP_MERGE_N, OP_RD_PREV,
		OP_MERGE_P, OP_KILL, OP_WB, OP_FIN
	} op_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_INIT, S_IDLE, S_GO, S_A_RD, S_A_EV, S_A_SPLIT, S_A_TAKE,
		S_LNK_RD, S_LNK_EV, S_F_RD, S_F_EV, S_N_RD, S_N_EV, S_P_RD, S_P_EV,
		S_P_KILL, S_WB, S_FIN
	} state_t;

	typedef enum logic [1:0] {RET_ALLOC, RET_NEXT, RET_PREV, RET_NONE} ret_t;

	typedef struct packed {
		op_t               op;
		logic [STAT_W-1:0] fst;
		logic              fpay;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_free;
		logic is_free;
		logic req_zero;
		logic blk_ok;
		logic oth_ok;
		logic lnk_ok;
		logic prev_ok;
		logic has_prev;
		logic rd_valid;
		logic rd_live;
		logic rd_free;
		logic fit;
		logic split;
	} dp_stat_t;

	function automatic logic ofs_ok(input logic [OFS_W-1:0] o, input logic [ARENA_W-1:0] a);
		return (o < {1'b0, a}) && (o[ALIGN_SH-1:0] == '0);
	endfunction

	function automatic logic [IDX_W-1:0] ofs_idx(input logic [OFS_W-1:0] o);
		return o[ALIGN_SH +: IDX_W];
	endfunction

endpackage

[rtl/ffa_ram.sv]
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/ffa_ctrl.sv]
module ffa_ctrl import ffa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t st,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;
	ret_t ret_q, ret_d;
	logic [STAT_W-1:0] fst_q, fst_d;
	logic fpay_q, fpay_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ret_q   <= RET_ALLOC;
			fst_q   <= ST_OK;
			fpay_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			fst_q   <= fst_d;
			fpay_q  <= fpay_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		fst_d   = fst_q;
		fpay_d  = fpay_q;
		case (state_q)
			S_CLEAR: if (st.clr_last) state_d = S_INIT;
			S_INIT: state_d = S_IDLE;
			S_IDLE: if (in_valid && st.out_free) state_d = S_GO;
			S_GO: begin
				if (st.is_free) begin
					state_d = S_F_RD;
				end else if (st.req_zero) begin
					fst_d   = ST_ZERO;
					fpay_d  = 1'b0;
					state_d = S_FIN;
				end else begin
					state_d = S_A_RD;
				end
			end
			S_A_RD: begin
				if (st.blk_ok) begin
					state_d = S_A_EV;
				end else begin
					fst_d   = ST_NOFIT;
					fpay_d  = 1'b0;
					state_d = S_FIN;
				end
			end
			S_A_EV: begin
				if (!st.rd_valid) begin
					fst_d   = ST_NOFIT;
					fpay_d  = 1'b0;
					state_d = S_FIN;
				end else if (st.fit) begin
					fst_d   = ST_OK;
					fpay_d  = 1'b1;
					// only a split leaves a block whose back-link needs updating
					ret_d   = st.split ? RET_ALLOC : RET_NONE;
					state_d = st.split ? S_A_SPLIT : S_A_TAKE;
				end else begin
					state_d = S_A_RD;
				end
			end
			S_A_SPLIT: state_d = S_A_TAKE;
			S_A_TAKE: state_d = (fpay_q && ret_q == RET_ALLOC && st.lnk_ok) ? S_LNK_RD : S_FIN;
			S_LNK_RD: begin
				if (st.lnk_ok) begin
					state_d = S_LNK_EV;
				end else begin
					state_d = (ret_q == RET_NEXT) ? S_P_RD : S_FIN;
				end
			end
			S_LNK_EV: state_d = (ret_q == RET_NEXT) ? S_P_RD : S_FIN;
			S_F_RD: begin
				if (st.blk_ok) begin
					state_d = S_F_EV;
				end else begin
					fst_d   = ST_BAD;
					fpay_d  = 1'b0;
					state_d = S_FIN;
				end
			end
			S_F_EV: begin
				fpay_d = 1'b0;
				if (st.rd_live) begin
					fst_d   = ST_OK;
					state_d = S_N_RD;
				end else begin
					fst_d   = ST_BAD;
					state_d = S_FIN;
				end
			end
			S_N_RD: state_d = st.oth_ok ? S_N_EV : S_P_RD;
			S_N_EV: begin
				if (st.rd_free) begin
					ret_d   = RET_NEXT;
					state_d = S_LNK_RD;
				end else begin
					state_d = S_P_RD;
				end
			end
			S_P_RD: state_d = (st.has_prev && st.prev_ok) ? S_P_EV : S_WB;
			S_P_EV: state_d = st.rd_free ? S_P_KILL : S_WB;
			S_P_KILL: begin
				ret_d   = RET_PREV;
				state_d = S_LNK_RD;
			end
			S_WB: state_d = S_FIN;
			S_FIN: state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
		// a size write reformats the arena
		if (cfg_we) begin
			state_d = S_CLEAR;
		end
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		cmd.op   = OP_NOP;
		cmd.fst  = fst_q;
		cmd.fpay = fpay_q;
		case (state_q)
			S_CLEAR: cmd.op = OP_CLR;
			S_INIT: cmd.op = OP_INIT;
			S_IDLE: begin
				in_ready = st.out_free;
				if (in_valid && st.out_free) cmd.op = OP_START;
			end
			S_A_RD, S_F_RD: cmd.op = OP_RD_BLK;
			S_A_EV: cmd.op = OP_EVAL_A;
			S_A_SPLIT: cmd.op = OP_SPLIT;
			S_A_TAKE: cmd.op = OP_TAKE;
			S_LNK_RD: cmd.op = OP_LNK_RD;
			S_LNK_EV: if (st.rd_valid) cmd.op = OP_LNK_WR;
			S_F_EV: if (st.rd_live) cmd.op = OP_EVAL_F;
			S_N_RD: cmd.op = OP_RD_OTH;
			S_N_EV: if (st.rd_free) cmd.op = OP_MERGE_N;
			S_P_RD: cmd.op = OP_RD_PREV;
			S_P_EV: if (st.rd_free) cmd.op = OP_MERGE_P;
			S_P_KILL: cmd.op = OP_KILL;
			S_WB: cmd.op = OP_WB;
			S_FIN: cmd.op = OP_FIN;
			default: cmd.op = OP_NOP;
		endcase
	end

endmodule

[rtl/ffa_dp.sv]
module ffa_dp import ffa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [ARENA_W-1:0]  cfg_data,
	input  logic                in_cmd,
	input  logic [REQ_W-1:0]    in_req,
	input  logic [FOFS_W-1:0]   in_fofs,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [STAT_W-1:0]   out_status,
	output logic [FOFS_W-1:0]   out_payload,
	output logic [ARENA_W-1:0]  out_used,
	input  dp_cmd_t             cmd,
	output dp_stat_t            st
);

	localparam logic [OFS_W-1:0]   HDR_O = OFS_W'(HEADER_BYTES);
	localparam logic [SIZE_W-1:0]  HDR_S = SIZE_W'(HEADER_BYTES);
	localparam logic [NEED_W-1:0]  ALN_M = NEED_W'(ALIGN_BYTES - 1);
	localparam logic [NEED_W-1:0]  MIN_N = NEED_W'(MIN_PAYLOAD_BYTES);
	localparam logic [NEED_W-1:0]  SPL_N = NEED_W'(HEADER_BYTES + MIN_PAYLOAD_BYTES);
	localparam logic [ARENA_W-1:0] A_LO  = ARENA_W'(HEADER_BYTES + MIN_PAYLOAD_BYTES);
	localparam logic [ARENA_W-1:0] A_HI  = ARENA_W'(ARENA_MAX_BYTES);

	logic [ARENA_W-1:0] arena_q, used_q;
	logic [NEED_W-1:0]  need_q;
	logic               cmd_q, req_zero_q;
	logic [OFS_W-1:0]   blk_q, oth_q, lnk_q;
	logic [IDX_W-1:0]   lnk_src_q, clr_q;
	tag_t               tag_q;
	logic               out_valid_q;
	logic [STAT_W-1:0]  status_q;
	logic [FOFS_W-1:0]  payload_q;
	logic [ARENA_W-1:0] used_out_q;

	logic [TAG_W-1:0] ram_rdata, wdata;
	tag_t             rd, wtag, res_tag, rd_freed;
	logic             we;
	logic [IDX_W-1:0] waddr, raddr;
	logic [NEED_W-1:0] rnd, need_in, size_n;
	logic [OFS_W-1:0] res_ofs, prev_ofs;
	logic [SIZE_W-1:0] res_size, mn_size, mp_size;

	assign rd       = tag_t'(ram_rdata);
	assign rnd      = ({1'b0, in_req} + ALN_M) & ~ALN_M;
	assign need_in  = (rnd < MIN_N) ? MIN_N : rnd;
	assign size_n   = NEED_W'(rd.size);
	assign res_ofs  = blk_q + HDR_O + need_q[OFS_W-1:0];
	assign prev_ofs = {{(OFS_W-IDX_W-ALIGN_SH){1'b0}}, tag_q.prev, {ALIGN_SH{1'b0}}};
	assign res_size = tag_q.size - need_q[SIZE_W-1:0] - HDR_S;
	assign mn_size  = tag_q.size + HDR_S + rd.size;
	assign mp_size  = rd.size + HDR_S + tag_q.size;

	always_comb begin
		res_tag          = '0;
		res_tag.valid    = 1'b1;
		res_tag.has_prev = 1'b1;
		res_tag.size     = res_size;
		res_tag.prev     = ofs_idx(blk_q);
	end

	always_comb begin
		rd_freed       = rd;
		rd_freed.alloc = 1'b0;
	end

	always_comb begin
		st.clr_last = (clr_q == IDX_W'(DEPTH - 1));
		st.out_free = !out_valid_q;
		st.is_free  = cmd_q;
		st.req_zero = req_zero_q;
		st.blk_ok   = ofs_ok(blk_q, arena_q);
		st.oth_ok   = ofs_ok(oth_q, arena_q);
		st.lnk_ok   = ofs_ok(lnk_q, arena_q);
		st.prev_ok  = ofs_ok(prev_ofs, arena_q);
		st.has_prev = tag_q.has_prev;
		st.rd_valid = rd.valid;
		st.rd_live  = rd.valid && rd.alloc;
		st.rd_free  = rd.valid && !rd.alloc;
		st.fit      = rd.valid && !rd.alloc && (size_n >= need_q);
		st.split    = (size_n >= need_q + SPL_N) && ofs_ok(res_ofs, arena_q);
	end

	// memory port selection
	always_comb begin
		we    = 1'b0;
		waddr = ofs_idx(blk_q);
		wtag  = '0;
		raddr = ofs_idx(blk_q);
		case (cmd.op)
			OP_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			OP_INIT: begin
				we         = 1'b1;
				waddr      = '0;
				wtag.valid = 1'b1;
				wtag.size  = SIZE_W'(arena_q - ARENA_W'(HEADER_BYTES));
			end
			OP_SPLIT: begin
				we    = 1'b1;
				waddr = ofs_idx(res_ofs);
				wtag  = res_tag;
			end
			OP_TAKE: begin
				we         = 1'b1;
				wtag       = tag_q;
				wtag.alloc = 1'b1;
			end
			OP_LNK_RD: raddr = ofs_idx(lnk_q);
			OP_LNK_WR: begin
				we            = 1'b1;
				waddr         = ofs_idx(lnk_q);
				wtag          = rd;
				wtag.has_prev = 1'b1;
				wtag.prev     = lnk_src_q;
			end
			OP_RD_OTH: raddr = ofs_idx(oth_q);
			OP_MERGE_N: begin
				we    = 1'b1;
				waddr = ofs_idx(oth_q);
			end
			OP_RD_PREV: raddr = tag_q.prev;
			OP_MERGE_P: begin
				we        = 1'b1;
				waddr     = ofs_idx(oth_q);
				wtag      = rd;
				wtag.size = mp_size;
			end
			OP_KILL: we = 1'b1;
			OP_WB: begin
				we   = 1'b1;
				wtag = tag_q;
			end
			default: we = 1'b0;
		endcase
	end

	assign wdata = TAG_W'(wtag);

	ffa_ram #(
		.WIDTH(TAG_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_q     <= A_HI;
			used_q      <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			cmd_q       <= 1'b0;
			req_zero_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_INIT: used_q <= '0;
				OP_START: begin
					cmd_q      <= in_cmd;
					req_zero_q <= (in_req == '0);
				end
				OP_TAKE: used_q <= used_q + ARENA_W'(tag_q.size);
				OP_EVAL_F: used_q <= used_q - ARENA_W'(rd.size);
				OP_FIN: out_valid_q <= 1'b1;
				default: used_q <= used_q;
			endcase
			if (cfg_we) begin
				clr_q <= '0;
			end else if (cmd.op == OP_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				if (cfg_data < A_LO) begin
					arena_q <= A_LO;
				end else if (cfg_data > A_HI) begin
					arena_q <= A_HI;
				end else begin
					arena_q <= cfg_data;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_START: begin
				need_q <= need_in;
				blk_q  <= in_cmd ? OFS_W'(in_fofs) - HDR_O : '0;
			end
			OP_EVAL_A: begin
				tag_q <= rd;
				if (!st.fit) blk_q <= blk_q + HDR_O + OFS_W'(rd.size);
			end
			OP_SPLIT: begin
				tag_q.size <= need_q[SIZE_W-1:0];
				lnk_q      <= res_ofs + HDR_O + OFS_W'(res_size);
				lnk_src_q  <= ofs_idx(res_ofs);
			end
			OP_EVAL_F: begin
				tag_q <= rd_freed;
				oth_q <= blk_q + HDR_O + OFS_W'(rd.size);
			end
			OP_MERGE_N: begin
				tag_q.size <= mn_size;
				lnk_q      <= blk_q + HDR_O + OFS_W'(mn_size);
				lnk_src_q  <= ofs_idx(blk_q);
			end
			OP_RD_PREV: oth_q <= prev_ofs;
			OP_MERGE_P: begin
				lnk_q     <= oth_q + HDR_O + OFS_W'(mp_size);
				lnk_src_q <= ofs_idx(oth_q);
			end
			OP_FIN: begin
				status_q   <= cmd.fst;
				payload_q  <= cmd.fpay ? FOFS_W'(blk_q + HDR_O) : '0;
				used_out_q <= used_q;
			end
			default: tag_q <= tag_q;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign out_status  = status_q;
	assign out_payload = payload_q;
	assign out_used    = used_out_q;

endmodule

[rtl/first_fit_arena_allocator_unit.sv]
// first-fit heap arena allocator with boundary tags and coalescing
//
// input channel (in_valid/in_ready): cmd 0 allocates request_bytes, cmd 1
// releases the payload at free_offset. each beat yields exactly one output
// beat (out_valid/out_ready) with status, payload_offset and used_bytes.
// one item is in flight at a time; a new beat is taken once the previous
// result has left the output register.
// an allocate walks the block headers first-fit, one tag memory read per
// header visited, then takes the block, splitting it when the remainder is
// large enough and then updating the back-link of the following block unless
// the remainder ends the arena; a zero-size request skips the walk. a free
// merges the block with a free neighbour on either side.
// writing arena_bytes (arena_bytes_we) reformats the arena: a clear pass
// over all 512 tag memory entries then an init step, with in_ready low.
// after reset the same clear pass runs with a 4096 byte arena.
// a stalled receiver holds the result; no further beat is accepted meanwhile.
module first_fit_arena_allocator_unit import ffa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                arena_bytes_we,
	input  logic [ARENA_W-1:0]  arena_bytes,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  logic [REQ_W-1:0]    request_bytes,
	input  logic [FOFS_W-1:0]   free_offset,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STAT_W-1:0]   status,
	output logic [FOFS_W-1:0]   payload_offset,
	output logic [ARENA_W-1:0]  used_bytes
);

	dp_cmd_t  dcmd;
	dp_stat_t dst;

	ffa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (arena_bytes_we),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.st      (dst),
		.cmd     (dcmd)
	);

	ffa_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (arena_bytes_we),
		.cfg_data   (arena_bytes),
		.in_cmd     (cmd),
		.in_req     (request_bytes),
		.in_fofs    (free_offset),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.out_status (status),
		.out_payload(payload_offset),
		.out_used   (used_bytes),
		.cmd        (dcmd),
		.st         (dst)
	);

endmodule

[rtl/ffa_chk.sv]
`include "assert_macros.svh"

module ffa_chk import ffa_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [STAT_W-1:0]  status,
	input logic [FOFS_W-1:0]  payload_offset,
	input logic [ARENA_W-1:0] used_bytes
);

	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(payload_offset) && $stable(used_bytes))
	`CHK_IMPLY(a_pay_zero, clk, arst_n, out_valid && status != ST_OK, payload_offset == '0)
	`CHK_NEXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready && !out_valid)
	`CHK_IMPLY(a_used_max, clk, arst_n, out_valid, used_bytes <= ARENA_W'(ARENA_MAX_BYTES))

endmodule

bind first_fit_arena_allocator_unit ffa_chk u_chk (.*);
